[hw/rtl/hds_pkg.sv]
`default_nettype none
package hds_pkg;

    localparam int CELL_BITS  = 16;
    localparam int MAX_GRID   = 1024;
    localparam int IDX_BITS   = $clog2(MAX_GRID);
    localparam int GRID_BITS  = IDX_BITS + 1;
    localparam int COEFF_BITS = 15;
    localparam int K_SHIFT    = 16;
    localparam int MIN_GRID   = 3;

    localparam int GRID_RESET  = 100;
    localparam int COEFF_RESET = 15729;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Datapath widths: four-neighbour sum, signed Laplacian, product, accumulator.
    localparam int NSUM_BITS = CELL_BITS + 2;
    localparam int LAP_BITS  = CELL_BITS + 3;
    localparam int PROD_BITS = LAP_BITS + COEFF_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 1;

    typedef logic [CELL_BITS-1:0]  t_cell;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [GRID_BITS-1:0]  t_grid;
    typedef logic [COEFF_BITS-1:0] t_coeff;

    typedef enum logic {
        REG_GRID_SIZE  = 1'b0,
        REG_DIFF_COEFF = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cell                 center;
        logic [NSUM_BITS-1:0]  nsum;
        t_idx                  row;
        t_idx                  col;
        logic                  last;
    } t_stencil_req;

endpackage
`default_nettype wire

[hw/rtl/hds_cell_if.sv]
`default_nettype none
interface hds_cell_if
    import hds_pkg::*;
;
    logic  valid;
    logic  ready;
    t_cell cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/hds_result_if.sv]
`default_nettype none
interface hds_result_if
    import hds_pkg::*;
;
    logic  valid;
    logic  ready;
    t_cell new_value;
    t_idx  out_row;
    t_idx  out_col;
    logic  frame_last;

    modport source (output valid, output new_value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input new_value, input out_row, input out_col,
                    input frame_last, output ready);
endinterface
`default_nettype wire

[hw/rtl/hds_ram.sv]
`default_nettype none
module hds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/hds_datapath.sv]
`default_nettype none
module hds_datapath
    import hds_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_coeff       i_coeff,
    input  wire logic         i_req_valid,
    input  wire t_stencil_req i_req,
    output logic              o_req_ready,
    hds_result_if.source      o_result
);

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (K_SHIFT - 1);

    // Stage A: Laplacian.
    logic                        r_a_valid;
    t_cell                       r_a_center;
    logic signed [LAP_BITS-1:0]  r_a_lap;
    t_idx                        r_a_row;
    t_idx                        r_a_col;
    logic                        r_a_last;
    // Stage B: coefficient product.
    logic                        r_b_valid;
    t_cell                       r_b_center;
    logic signed [PROD_BITS-1:0] r_b_prod;
    t_idx                        r_b_row;
    t_idx                        r_b_col;
    logic                        r_b_last;
    // Output register.
    logic                        r_o_valid;
    t_cell                       r_o_value;
    t_idx                        r_o_row;
    t_idx                        r_o_col;
    logic                        r_o_last;

    logic                        en_a;
    logic                        en_b;
    logic                        en_o;
    logic signed [LAP_BITS-1:0]  n_a_lap;
    logic signed [PROD_BITS-1:0] n_b_prod;
    logic signed [ACC_BITS-1:0]  acc;
    t_cell                       n_o_value;

    assign en_o        = !r_o_valid || o_result.ready;
    assign en_b        = !r_b_valid || en_o;
    assign en_a        = !r_a_valid || en_b;
    assign o_req_ready = en_a;

    assign n_a_lap  = $signed({1'b0, i_req.nsum}) - $signed({1'b0, i_req.center, 2'b00});
    assign n_b_prod = PROD_BITS'($signed({1'b0, i_coeff})) * PROD_BITS'(r_a_lap);
    assign acc      = $signed(ACC_BITS'({r_b_center, {K_SHIFT{1'b0}}}))
                    + ACC_BITS'(r_b_prod) + ROUND_HALF;

    // Round to nearest, then clamp to the unsigned cell range.
    always_comb begin
        if (acc[ACC_BITS-1]) begin
            n_o_value = '0;
        end else if (|acc[ACC_BITS-2:K_SHIFT+CELL_BITS]) begin
            n_o_value = '1;
        end else begin
            n_o_value = acc[K_SHIFT+CELL_BITS-1:K_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_req_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (en_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_center <= i_req.center;
            r_a_lap    <= n_a_lap;
            r_a_row    <= i_req.row;
            r_a_col    <= i_req.col;
            r_a_last   <= i_req.last;
        end
        if (en_b) begin
            r_b_center <= r_a_center;
            r_b_prod   <= n_b_prod;
            r_b_row    <= r_a_row;
            r_b_col    <= r_a_col;
            r_b_last   <= r_a_last;
        end
        if (en_o) begin
            r_o_value <= n_o_value;
            r_o_row   <= r_b_row;
            r_o_col   <= r_b_col;
            r_o_last  <= r_b_last;
        end
    end

    assign o_result.valid      = r_o_valid;
    assign o_result.new_value  = r_o_value;
    assign o_result.out_row    = r_o_row;
    assign o_result.out_col    = r_o_col;
    assign o_result.frame_last = r_o_last;

endmodule
`default_nettype wire

[hw/rtl/heat_diffusion_stencil_top.sv]
// Five-point heat-diffusion stencil over a raster stream of cells.
// A result passes stage 1, stages A and B and the output register after the beat of
// the cell below-right of it. Throughput: one cell per cycle when not stalled; the
// line-store read and write-back overlap; the arithmetic is a three-stage pipeline.
// Reset is synchronous, active low; it restores the registers to their defaults
// and clears counters, window and pipeline valids; the line stores are not cleared.
`default_nettype none
module heat_diffusion_stencil_top
    import hds_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    hds_cell_if.sink                      i_cell,
    hds_result_if.source                  o_result
);

    t_grid  r_grid_size;
    t_coeff r_coeff;
    t_idx   r_row;
    t_idx   r_col;
    t_idx   n_row;
    t_idx   n_col;

    // Window: 0 current row c-1, 1 previous row c-1, 2 previous row c-2, 3 older row c-1.
    t_cell  r_win [4];

    logic   r_s1_valid;
    t_idx   r_s1_addr;
    t_cell  r_s1_cell;
    logic   r_s1_has;
    t_idx   r_s1_row;
    t_idx   r_s1_col;
    logic   r_s1_last;

    t_reg_idx     reg_idx;
    logic         cfg_wr;
    t_grid        grid_eff;
    t_grid        grid_m1;
    logic         col_end;
    logic         row_end;
    logic         accept;
    logic         s1_en;
    logic         s1_move;
    logic         req_ready;
    t_cell        prev_rd;
    t_cell        older_rd;
    t_stencil_req req;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_GRID_SIZE:  prdata = APB_DATA_BITS'(r_grid_size);
            REG_DIFF_COEFF: prdata = APB_DATA_BITS'(r_coeff);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if (r_grid_size < GRID_BITS'(MIN_GRID)) begin
            grid_eff = GRID_BITS'(MIN_GRID);
        end else if (r_grid_size > GRID_BITS'(MAX_GRID)) begin
            grid_eff = GRID_BITS'(MAX_GRID);
        end else begin
            grid_eff = r_grid_size;
        end
    end

    assign grid_m1 = grid_eff - GRID_BITS'(1);
    assign col_end = {1'b0, r_col} == grid_m1;
    assign row_end = {1'b0, r_row} == grid_m1;

    always_comb begin
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + IDX_BITS'(1);
        end else begin
            n_col = r_col + IDX_BITS'(1);
            n_row = r_row;
        end
    end

    // Stage 1 holds the cell whose line-store data is on the RAM outputs.
    assign s1_en          = !r_s1_valid || !r_s1_has || req_ready;
    assign s1_move        = r_s1_valid && s1_en;
    assign i_cell.ready   = s1_en;
    assign accept         = i_cell.valid && s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_BITS'(GRID_RESET);
            r_coeff     <= COEFF_BITS'(COEFF_RESET);
            r_row       <= '0;
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_idx)
                    REG_GRID_SIZE: begin
                        r_grid_size <= pwdata[GRID_BITS-1:0];
                        r_row       <= '0;
                        r_col       <= '0;
                    end
                    REG_DIFF_COEFF: begin
                        r_coeff <= pwdata[COEFF_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (s1_en) begin
                r_s1_valid <= i_cell.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= r_col;
            r_s1_cell <= i_cell.cell_value;
            r_s1_has  <= (r_row >= IDX_BITS'(2)) && (r_col >= IDX_BITS'(2));
            r_s1_row  <= r_row - IDX_BITS'(1);
            r_s1_col  <= r_col - IDX_BITS'(1);
            r_s1_last <= row_end && col_end;
        end
    end

    // An entry is read again only a full row (at least three beats) after its
    // previous read and at least two beats after its write-back, so reads and
    // writes of the same entry never overlap.
    hds_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (MAX_GRID)
    ) u_prev_row (
        .i_clk     (i_clk),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_cell),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (prev_rd)
    );

    hds_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (MAX_GRID)
    ) u_older_row (
        .i_clk     (i_clk),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (prev_rd),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (older_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
            r_win[3] <= '0;
        end else if (s1_move) begin
            r_win[0] <= r_s1_cell;
            r_win[1] <= prev_rd;
            r_win[2] <= (r_s1_addr == '0) ? '0 : r_win[1];
            r_win[3] <= older_rd;
        end
    end

    assign req.center = r_win[1];
    assign req.nsum   = NSUM_BITS'(r_win[3]) + NSUM_BITS'(r_win[0])
                      + NSUM_BITS'(r_win[2]) + NSUM_BITS'(prev_rd);
    assign req.row    = r_s1_row;
    assign req.col    = r_s1_col;
    assign req.last   = r_s1_last;

    hds_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coeff     (r_coeff),
        .i_req_valid (r_s1_valid && r_s1_has),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

[sim/heat_diffusion_stencil_top_tb.sv]
module heat_diffusion_stencil_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hds_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_STALL   = 300;
    localparam int DRAIN_CYCLES = 12;

    // Window slots around the cell being updated.
    localparam int WIN_DOWN   = 0;
    localparam int WIN_CENTER = 1;
    localparam int WIN_LEFT   = 2;
    localparam int WIN_UP     = 3;

    typedef struct packed {
        t_cell new_value;
        t_idx  row;
        t_idx  col;
        logic  last;
    } t_cell_update;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    hds_cell_if   cell_bus ();
    hds_result_if result_bus ();

    logic  cell_valid   = 1'b0;
    t_cell cell_data    = '0;
    logic  result_ready = 1'b0;
    logic  cell_beat    = 1'b0;

    assign cell_bus.valid      = cell_valid;
    assign cell_bus.cell_value = cell_data;
    assign result_bus.ready    = result_ready;

    heat_diffusion_stencil_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_cell   (cell_bus),
        .o_result (result_bus)
    );

    t_cell        cell_queue[$];
    t_cell_update pending_updates[$];
    t_cell_update oldest_update;
    int           mismatch_count = 0;
    int           src_idle_pct   = 22;
    int           snk_idle_pct   = 62;
    int           cycle_count    = 0;
    int           stall_from     = -1000000;

    // Predictor state.
    t_grid  grid_reg  = t_grid'(GRID_RESET);
    t_coeff coeff_reg = t_coeff'(COEFF_RESET);
    t_cell  prev_row  [MAX_GRID];
    t_cell  older_row [MAX_GRID];
    t_cell  win       [4];
    int     row_cnt   = 0;
    int     col_cnt   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("heat_diffusion_stencil_top_tb failed");
        $finish;
    end

    function automatic t_cell diffuse(input t_cell center, input t_cell up, input t_cell down,
                                      input t_cell left, input t_cell right);
        longint lap;
        longint acc;
        longint top;
        top = (longint'(1) << CELL_BITS) - 1;
        lap = longint'(up) + longint'(down) + longint'(left) + longint'(right)
            - 4 * longint'(center);
        acc = (longint'(center) << K_SHIFT) + longint'(coeff_reg) * lap
            + (longint'(1) << (K_SHIFT - 1));
        if (acc < 0) begin
            return '0;
        end
        acc = acc >>> K_SHIFT;
        return (acc > top) ? '1 : t_cell'(acc);
    endfunction

    function automatic void predict_cell_update(input t_cell new_cell);
        int           n;
        int           r;
        int           c;
        t_cell        prev_at_col;
        t_cell        older_at_col;
        t_cell_update upd;
        n = (grid_reg < MIN_GRID) ? MIN_GRID : (grid_reg > MAX_GRID) ? MAX_GRID : int'(grid_reg);
        r = row_cnt;
        c = col_cnt;
        if (r >= n || c >= n) begin
            r = 0;
            c = 0;
        end
        // The previous-row entry at the incoming column is the right neighbour.
        prev_at_col  = prev_row[c];
        older_at_col = older_row[c];
        if (r >= 2 && c >= 2) begin
            upd.new_value = diffuse(win[WIN_CENTER], win[WIN_UP], win[WIN_DOWN],
                                    win[WIN_LEFT], prev_at_col);
            upd.row  = t_idx'(r - 1);
            upd.col  = t_idx'(c - 1);
            upd.last = (r == n - 1) && (c == n - 1);
            pending_updates.push_back(upd);
        end
        win[WIN_LEFT]   = (c == 0) ? '0 : win[WIN_CENTER];
        win[WIN_CENTER] = prev_at_col;
        win[WIN_UP]     = older_at_col;
        win[WIN_DOWN]   = new_cell;
        older_row[c] = prev_at_col;
        prev_row[c]  = new_cell;
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) begin
                r = 0;
            end
        end
        row_cnt = r;
        col_cnt = c;
    endfunction

    function automatic void flag_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Monitor: follows register writes and input beats, checks output beats.
    always @(posedge i_clk) begin
        cell_beat = i_rst_n && cell_valid && cell_bus.ready;
        if (!i_rst_n) begin
            grid_reg  = t_grid'(GRID_RESET);
            coeff_reg = t_coeff'(COEFF_RESET);
            row_cnt   = 0;
            col_cnt   = 0;
            for (int i = 0; i < 4; i++) begin
                win[i] = '0;
            end
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[2]))
                    REG_GRID_SIZE: begin
                        grid_reg = pwdata[GRID_BITS-1:0];
                        row_cnt  = 0;
                        col_cnt  = 0;
                    end
                    REG_DIFF_COEFF: begin
                        coeff_reg = pwdata[COEFF_BITS-1:0];
                    end
                endcase
            end
            if (cell_beat) begin
                predict_cell_update(cell_data);
            end
            if (result_bus.valid && result_ready) begin
                if (pending_updates.size() == 0) begin
                    $display("%0t: unexpected result expected none got value %0d row %0d col %0d last %b",
                             $time, result_bus.new_value, result_bus.out_row,
                             result_bus.out_col, result_bus.frame_last);
                    mismatch_count++;
                end else begin
                    oldest_update = pending_updates.pop_front();
                    flag_field("new_value", oldest_update.new_value, result_bus.new_value);
                    flag_field("out_row", oldest_update.row, result_bus.out_row);
                    flag_field("out_col", oldest_update.col, result_bus.out_col);
                    flag_field("frame_last", oldest_update.last, result_bus.frame_last);
                end
            end
        end
    end

    // Driver: a cell stays on the bus until its beat.
    always @(negedge i_clk) begin
        if (!cell_valid || cell_beat) begin
            if (cell_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                cell_valid <= 1'b1;
                cell_data  <= cell_queue.pop_front();
            end else begin
                cell_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        result_ready <= (cycle_count - stall_from >= LONG_STALL)
                        && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic write_register(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (cell_queue.size() != 0 || cell_valid) @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_plus_frame(input t_cell center, input t_cell rim);
        for (int i = 0; i < 9; i++) begin
            cell_queue.push_back((i == 4) ? center : rim);
        end
    endtask

    task automatic queue_random_cells(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       cell_queue.push_back('0);
                1:       cell_queue.push_back('1);
                2, 3, 4: cell_queue.push_back(t_cell'($urandom_range(16'h3000, 16'h3400)));
                default: cell_queue.push_back(t_cell'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    initial begin
        int random_sent;
        int count;
        int grid_now;
        int pick;
        bit stall_done;
        random_sent = 0;
        stall_done  = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Clamping at both ends with a coefficient above the stable limit.
        write_register(REG_GRID_SIZE, 32'd3);
        write_register(REG_DIFF_COEFF, 32'd32767);
        queue_plus_frame('0, '1);
        drain();
        queue_plus_frame('1, '0);
        drain();

        // Grid rewritten mid-frame to a value below the minimum.
        queue_random_cells(2);
        drain();
        write_register(REG_GRID_SIZE, 32'd0);
        write_register(REG_DIFF_COEFF, 32'd0);
        queue_plus_frame(16'h5555, 16'hAAAA);
        drain();

        // Oversized grid acts as the largest one; a few rows are enough.
        write_register(REG_GRID_SIZE, 32'd2047);
        write_register(REG_DIFF_COEFF, 32'd16384);
        queue_random_cells(2 * MAX_GRID + 40);
        drain();
        grid_now = MAX_GRID;

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                src_idle_pct = 22;
                snk_idle_pct = 62;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 62;
                snk_idle_pct = 22;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    pick = $urandom_range(0, 2);
                end else if (pick == 1) begin
                    pick = $urandom_range(13, 40);
                end else begin
                    pick = $urandom_range(3, 12);
                end
                write_register(REG_GRID_SIZE, 32'(pick));
                grid_now = (pick < MIN_GRID) ? MIN_GRID : pick;
            end
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       write_register(REG_DIFF_COEFF, 32'd0);
                    1:       write_register(REG_DIFF_COEFF, 32'd16384);
                    2:       write_register(REG_DIFF_COEFF, 32'd32767);
                    default: write_register(REG_DIFF_COEFF, 32'($urandom_range(0, 16384)));
                endcase
            end
            count = $urandom_range(1, 3 * grid_now * grid_now);
            if (count > 300) begin
                count = 300;
            end
            // Hold the output off while the sender keeps going so the block backs up.
            if (!stall_done && random_sent >= 2 * RANDOM_ITEMS / 3) begin
                stall_from = cycle_count;
                count      = 300;
                stall_done = 1'b1;
            end
            queue_random_cells(count);
            random_sent += count;
            drain();
        end

        if (mismatch_count == 0) begin
            $display("heat_diffusion_stencil_top_tb passed");
        end else begin
            $display("heat_diffusion_stencil_top_tb failed");
        end
        $finish;
    end

endmodule
